>>> hw/rtl/snb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snb_pkg: shared types, codes and arithmetic for the sigmoid neuron
// Q16.16 helpers, transaction payload types and the sigmoid lookup table.
// ----------------------------------------------------------------------------
package snb_pkg;

  localparam int MAX_INPUTS = 64;
  localparam int IDX_W      = $clog2(MAX_INPUTS);
  localparam int SIG_DEPTH  = 1024;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [31:0] SIG_HALF = 32'sd524288;

  // input kinds
  localparam logic [1:0] KIND_FWD    = 2'd0;
  localparam logic [1:0] KIND_TRAIN  = 2'd1;
  localparam logic [1:0] KIND_LOAD_W = 2'd2;
  localparam logic [1:0] KIND_LOAD_B = 2'd3;

  // roles
  localparam logic [1:0] ROLE_OUTPUT = 2'd0;
  localparam logic [1:0] ROLE_HIDDEN = 2'd1;

  // configuration register indexes
  localparam logic [7:0] CFG_ROLE = 8'd0;
  localparam logic [7:0] CFG_LR   = 8'd1;
  localparam logic [7:0] CFG_MOM  = 8'd2;
  localparam logic [7:0] CFG_BIN  = 8'd3;

  localparam logic RES_ACT = 1'b0;
  localparam logic RES_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   element_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] teach_value;
    logic               last;
  } snb_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_kind;
  } snb_out_t;

  typedef logic [16:0] sig_table_t [SIG_DEPTH];

  // saturate a 34-bit sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // round half up, drop 16 fraction bits, saturate
  function automatic logic signed [31:0] qround(input logic signed [65:0] p);
    logic signed [65:0] v;
    logic signed [49:0] s;
    v = p + 66'sd32768;
    s = 50'(v >>> 16);
    if (s > 50'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -50'sh8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // shift and subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t t;
    longint num;
    logic [63:0] mag, u, sum, term, e, den, one30;
    one30 = 64'd1 << 30;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      num  = longint'(i) * 16 - longint'(8) * SIG_DEPTH;
      mag  = (num < 0) ? 64'(-num) : 64'(num);
      u    = 64'(udiv64(mag << 26, 64'(SIG_DEPTH)));
      sum  = one30;
      term = one30;
      for (int k = 1; k <= 10; k++) begin
        term = udiv64((term * u) >> 30, 64'(k));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      e = sum;
      for (int k = 0; k < 4; k++) e = (e * e + (one30 >> 1)) >> 30;
      den = one30 + e;
      if (num >= 0) t[i] = 17'(udiv64((64'd1 << 46) + (den >> 1), den));
      else t[i] = 17'(udiv64((e << 16) + (den >> 1), den));
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

  // table address for a sum inside [-8,8)
  function automatic logic [SIG_IDX_W-1:0] sig_index(input logic signed [31:0] s);
    logic signed [31:0] off;
    off = s + SIG_HALF;
    return off[19 -: SIG_IDX_W];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sigmoid_neuron_backprop.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigmoid_neuron_backprop: sigmoid neuron with momentum back-propagation
// Q16.16 neuron sharing one multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one element transaction (forward, train,
//   load weight, load bias). in_stall is high while an element is being
//   worked on. Load transactions complete in the accept cycle. A forward
//   element multiplies and accumulates, when last adding the bias product
//   and table lookup. A train element forms the step, momentum delta, new
//   weight and error product, when last the bias update, and when opening
//   a run the error term first; the shared multiplier issues products in turn.
//   out_valid/out_stall/out_data carry the activation or error sum from an
//   output register; when out_stall holds a result, a further finished
//   result waits in its last step until the register frees.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write registers; cfg_ready is
//   always high. Reset (rst_n low, synchronous) restores register defaults,
//   clears all deltas, bias and run state; weights are undefined until loaded.
// ----------------------------------------------------------------------------
module sigmoid_neuron_backprop
  import snb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire snb_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output snb_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_F_MUL  = 5'd1;
  localparam logic [4:0] S_F_ACC  = 5'd2;
  localparam logic [4:0] S_F_BIAS = 5'd3;
  localparam logic [4:0] S_F_SIG  = 5'd4;
  localparam logic [4:0] S_EMIT   = 5'd5;
  localparam logic [4:0] S_E1     = 5'd6;
  localparam logic [4:0] S_E2     = 5'd7;
  localparam logic [4:0] S_E3     = 5'd8;
  localparam logic [4:0] S_T_STEP = 5'd9;
  localparam logic [4:0] S_T_S1   = 5'd10;
  localparam logic [4:0] S_T_D    = 5'd11;
  localparam logic [4:0] S_T_UD   = 5'd12;
  localparam logic [4:0] S_T_W    = 5'd13;
  localparam logic [4:0] S_T_WM   = 5'd14;
  localparam logic [4:0] S_T_ACC  = 5'd15;
  localparam logic [4:0] S_T_BIAS = 5'd16;
  localparam logic [4:0] S_F_ACT  = 5'd17;

  logic [4:0]  state_r, state_nxt;
  snb_in_t     item_r;
  logic        run_open_r, run_open_nxt;
  logic signed [31:0] rs_r, rs_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [31:0] bias_r, bias_nxt;
  logic [16:0] act_r, act_nxt;
  logic signed [31:0] step_r, step_nxt;
  logic signed [31:0] t1_r, t1_nxt;
  logic signed [31:0] ud_r, ud_nxt;
  logic signed [31:0] w_r, w_nxt;
  snb_out_t    res_r, res_nxt;
  logic [1:0]  role_r;
  logic [16:0] lr_r, mom_r;
  logic signed [31:0] bin_r;

  logic signed [31:0] weight_mem [MAX_INPUTS];
  logic signed [31:0] delta_mem  [MAX_INPUTS];
  logic signed [31:0] w_rd_r, d_rd_r;
  logic        dv_rd_r;
  logic [MAX_INPUTS-1:0] dvalid_r;
  logic [16:0] sig_rd_r;

  logic        out_valid_r;
  snb_out_t    out_r;

  logic        in_acc;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] q;
  logic signed [32:0] act_s, nact_s;
  logic        wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic signed [31:0] wr_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign act_s  = 33'(act_r);
  assign nact_s = 33'(ONE_Q16) - act_s;

  snb_mac u_mac (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .q    (q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r <= ROLE_OUTPUT;
      lr_r   <= 17'd6554;
      mom_r  <= 17'd0;
      bin_r  <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROLE: role_r <= cfg_data[1:0];
        CFG_LR:   lr_r   <= cfg_data[16:0];
        CFG_MOM:  mom_r  <= cfg_data[16:0];
        CFG_BIN:  bin_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight and delta memories
  assign wr_en   = (in_acc && in_data.kind == KIND_LOAD_W) || (state_r == S_T_WM);
  assign wr_addr = (state_r == S_T_WM) ? item_r.element_index : in_data.element_index;
  assign wr_data = (state_r == S_T_WM) ? w_r : in_data.sample_value;

  always_ff @(posedge clk) begin
    if (wr_en) weight_mem[wr_addr] <= wr_data;
    if (state_r == S_T_WM) delta_mem[item_r.element_index] <= ud_r;
    if (in_acc) begin
      w_rd_r  <= weight_mem[in_data.element_index];
      d_rd_r  <= delta_mem[in_data.element_index];
      dv_rd_r <= dvalid_r[in_data.element_index];
    end
  end

  // sigmoid table read, registered
  always_ff @(posedge clk) begin
    sig_rd_r <= SIG_TABLE[sig_index(rs_r)];
  end

  // delta valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) dvalid_r <= '0;
    else if (state_r == S_T_WM) dvalid_r[item_r.element_index] <= 1'b1;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    run_open_nxt = run_open_r;
    rs_nxt       = rs_r;
    err_nxt      = err_r;
    bias_nxt     = bias_r;
    act_nxt      = act_r;
    step_nxt     = step_r;
    t1_nxt       = t1_r;
    ud_nxt       = ud_r;
    w_nxt        = w_r;
    res_nxt      = res_r;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_LOAD_B: bias_nxt = in_data.sample_value;
            KIND_FWD: begin
              if (!run_open_r) rs_nxt = '0;
              run_open_nxt = 1'b1;
              state_nxt    = S_F_MUL;
            end
            KIND_TRAIN: begin
              if (!run_open_r) begin
                rs_nxt    = '0;
                state_nxt = S_E1;
              end else begin
                state_nxt = S_T_STEP;
              end
              run_open_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_F_MUL: begin
        mul_a     = 33'(w_rd_r);
        mul_b     = 33'(item_r.sample_value);
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        rs_nxt = sat_add(rs_r, q);
        if (item_r.last) begin
          mul_a     = 33'(bias_r);
          mul_b     = 33'(bin_r);
          state_nxt = S_F_BIAS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_F_BIAS: begin
        rs_nxt    = sat_add(rs_r, q);
        state_nxt = S_F_SIG;
      end
      // table read of the final sum is in flight
      S_F_SIG: begin
        state_nxt = S_F_ACT;
      end
      S_F_ACT: begin
        if (rs_r < -SIG_HALF) act_nxt = '0;
        else if (rs_r >= SIG_HALF) act_nxt = ONE_Q16;
        else act_nxt = sig_rd_r;
        rs_nxt       = '0;
        run_open_nxt = 1'b0;
        res_nxt      = '{result_value: 32'(act_nxt), result_kind: RES_ACT};
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      S_E1: begin
        if (role_r == ROLE_OUTPUT) begin
          mul_a = 33'(sat_sub(item_r.teach_value, 32'(act_r)));
          mul_b = act_s;
        end else begin
          mul_a = act_s;
          mul_b = nact_s;
        end
        state_nxt = S_E2;
      end
      S_E2: begin
        mul_a     = 33'(q);
        mul_b     = (role_r == ROLE_OUTPUT) ? nact_s : 33'(item_r.teach_value);
        state_nxt = S_E3;
      end
      S_E3: begin
        err_nxt   = q;
        state_nxt = S_T_STEP;
      end
      S_T_STEP: begin
        mul_a     = 33'(lr_r);
        mul_b     = 33'(err_r);
        state_nxt = S_T_S1;
      end
      S_T_S1: begin
        step_nxt  = q;
        mul_a     = 33'(q);
        mul_b     = 33'(item_r.sample_value);
        state_nxt = S_T_D;
      end
      S_T_D: begin
        t1_nxt    = q;
        mul_a     = dv_rd_r ? 33'(d_rd_r) : 33'sd0;
        mul_b     = 33'(mom_r);
        state_nxt = S_T_UD;
      end
      S_T_UD: begin
        ud_nxt    = sat_add(t1_r, q);
        state_nxt = S_T_W;
      end
      S_T_W: begin
        w_nxt     = sat_add(w_rd_r, ud_r);
        state_nxt = S_T_WM;
      end
      S_T_WM: begin
        mul_a     = 33'(w_r);
        mul_b     = 33'(err_r);
        state_nxt = S_T_ACC;
      end
      S_T_ACC: begin
        rs_nxt = sat_add(rs_r, q);
        if (item_r.last) begin
          mul_a     = 33'(step_r);
          mul_b     = 33'(bin_r);
          state_nxt = S_T_BIAS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_T_BIAS: begin
        bias_nxt     = sat_add(bias_r, q);
        run_open_nxt = 1'b0;
        res_nxt      = '{result_value: rs_r, result_kind: RES_ERR};
        state_nxt    = (role_r == ROLE_OUTPUT || role_r == ROLE_HIDDEN) ? S_EMIT : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      run_open_r <= 1'b0;
      rs_r       <= '0;
      err_r      <= '0;
      bias_r     <= '0;
      act_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      run_open_r <= run_open_nxt;
      rs_r       <= rs_nxt;
      err_r      <= err_nxt;
      bias_r     <= bias_nxt;
      act_r      <= act_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
    step_r <= step_nxt;
    t1_r   <= t1_nxt;
    ud_r   <= ud_nxt;
    w_r    <= w_nxt;
    res_r  <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
      out_r       <= res_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while sequencer busy");

  a_fwd_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F_ACT) |=> !run_open_r && (rs_r == 32'sd0))
    else $error("forward run not closed");

  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= ONE_Q16)
    else $error("activation out of range");

  a_delta_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_WM) |=> dvalid_r[$past(item_r.element_index)])
    else $error("delta written without valid bit");

endmodule
`default_nettype wire

>>> hw/rtl/snb_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snb_mac: shared Q16.16 multiplier
// Registers the full product; the rounded, saturated value is formed from it combinationally.
// ----------------------------------------------------------------------------
module snb_mac
  import snb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed [31:0]      q
);

  logic signed [65:0] prod_r;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign q = qround(prod_r);

endmodule
`default_nettype wire
